/* hw/rtl/cst_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the character stream tokenizer.
// No dependencies.
package cst_pkg;

  localparam int MAX_IDENT_LEN_DEFAULT = 35;

  localparam int KIND_W  = 4;
  localparam int VALUE_W = 32;
  localparam int LINE_W  = 32;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 6;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t K_SEMI    = 4'd0;
  localparam kind_t K_PLUS    = 4'd1;
  localparam kind_t K_MINUS   = 4'd2;
  localparam kind_t K_STAR    = 4'd3;
  localparam kind_t K_SLASH   = 4'd4;
  localparam kind_t K_LPAREN  = 4'd5;
  localparam kind_t K_RPAREN  = 4'd6;
  localparam kind_t K_INTLIT  = 4'd7;
  localparam kind_t K_CONOUT  = 4'd8;
  localparam kind_t K_UNKNOWN = 4'd9;
  localparam kind_t K_TOOLONG = 4'd10;

  localparam int KEYWORD_LEN = 6;
  localparam logic [CHAR_W-1:0] KEYWORD [KEYWORD_LEN] = '{
    8'h63, 8'h6F, 8'h6E, 8'h6F, 8'h75, 8'h74
  };

  typedef struct packed {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
    logic [LINE_W-1:0]         line;
    logic                      last;
  } token_t;

endpackage

/* hw/rtl/cst_char_if.sv */
`timescale 1ns / 1ps
// Input channel: one source byte or end-of-text mark per transfer.
// Depends on cst_pkg.
interface cst_char_if;
  logic                       valid;
  logic                       ready;
  logic [cst_pkg::CHAR_W-1:0] char_byte;
  logic                       end_of_input;

  modport source (output valid, char_byte, end_of_input, input ready);
  modport sink (input valid, char_byte, end_of_input, output ready);
endinterface

/* hw/rtl/cst_token_if.sv */
`timescale 1ns / 1ps
// Output channel: one token per transfer.
// Depends on cst_pkg.
interface cst_token_if;
  logic                                valid;
  logic                                ready;
  logic [cst_pkg::KIND_W-1:0]          token_kind;
  logic signed [cst_pkg::VALUE_W-1:0]  int_value;
  logic [cst_pkg::LINE_W-1:0]          line_number;
  logic                                last_of_run;

  modport source (output valid, token_kind, int_value, line_number, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, int_value, line_number, last_of_run,
                output ready);
endinterface

/* hw/rtl/char_stream_tokenizer.sv */
`timescale 1ns / 1ps
// Character stream tokenizer: scanner state, token logic and output queue.
// Depends on cst_pkg, cst_char_if and cst_token_if.
//
// Usage:
//   chars  : one ASCII byte per transfer, or end_of_input=1 to close the text.
//   tokens : token kind, literal value, line number, and last_of_run marking
//            the final token caused by one input byte (a byte may give two).
//   Each byte is scanned in the cycle it transfers; its tokens enter a
//   four-entry output queue and can be taken from the next cycle on.
//   Throughput is one byte per cycle while each byte gives at most one token
//   and tokens.ready stays high; the queue drains one token per cycle.
//   chars.ready is high while the queue has room for two tokens, so a
//   stalled receiver holds the input back after at most four queued tokens.
//   After an error token or end of text the block drops all further bytes
//   until reset. Synchronous reset empties the queue, returns the scanner
//   to idle and sets the line counter to 1.
module char_stream_tokenizer #(
  parameter int MAX_IDENT_LEN = cst_pkg::MAX_IDENT_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  cst_char_if.sink    chars,
  cst_token_if.source tokens
);
  import cst_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_INT   = 3'd1;
  localparam logic [2:0] PH_IDENT = 3'd2;
  localparam logic [2:0] PH_ENDED = 3'd3;
  localparam logic [2:0] PH_ERROR = 3'd4;

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_IDENT_LEN - 1);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic       emit;
    kind_t      kind;
    logic [2:0] phase;
    logic       newline;
    logic       start_int;
    logic       start_ident;
  } idle_res_t;

  logic [2:0]         phase;
  logic [VALUE_W-1:0] int_accum;
  logic [LEN_W-1:0]   ident_length;
  logic               keyword_prefix_ok;
  logic [LINE_W-1:0]  line_count;

  logic [2:0]         phase_next;
  logic [VALUE_W-1:0] int_accum_next;
  logic [LEN_W-1:0]   ident_length_next;
  logic               keyword_prefix_ok_next;
  logic [LINE_W-1:0]  line_count_next;

  token_t             queue [QDEPTH];
  logic [QPTR_W-1:0]  head;
  logic [QPTR_W-1:0]  tail;
  logic [QPTR_W:0]    count;

  logic               accept;
  logic               pop;
  logic               emit_a;
  logic               emit_b;
  kind_t              kind_a;
  kind_t              kind_b;
  logic [VALUE_W-1:0] value_a;
  logic [1:0]         n_push;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic idle_res_t idle_byte(input logic [CHAR_W-1:0] c);
    idle_res_t r;
    r = '{emit: 1'b1, kind: K_UNKNOWN, phase: PH_IDLE, newline: 1'b0,
          start_int: 1'b0, start_ident: 1'b0};
    case (c)
      8'h20, 8'h09, 8'h0D, 8'h0C: r.emit = 1'b0;
      8'h0A: begin
        r.emit    = 1'b0;
        r.newline = 1'b1;
      end
      8'h3B: r.kind = K_SEMI;
      8'h2B: r.kind = K_PLUS;
      8'h2D: r.kind = K_MINUS;
      8'h2A: r.kind = K_STAR;
      8'h2F: r.kind = K_SLASH;
      8'h28: r.kind = K_LPAREN;
      8'h29: r.kind = K_RPAREN;
      default: begin
        if (is_digit(c)) begin
          r.emit      = 1'b0;
          r.phase     = PH_INT;
          r.start_int = 1'b1;
        end else if (is_alpha(c) || c == 8'h5F) begin
          r.emit        = 1'b0;
          r.phase       = PH_IDENT;
          r.start_ident = 1'b1;
        end else begin
          r.phase = PH_ERROR;
        end
      end
    endcase
    return r;
  endfunction

  assign accept = chars.valid && chars.ready;
  assign pop    = tokens.valid && tokens.ready;

  // Scanner step
  always_comb begin
    idle_res_t         ib;
    logic              run_idle;
    logic [CHAR_W-1:0] c;
    logic              ident_ok;
    c        = chars.char_byte;
    ib       = idle_byte(c);
    run_idle = 1'b0;
    ident_ok = keyword_prefix_ok && (ident_length == LEN_W'(KEYWORD_LEN));

    phase_next             = phase;
    int_accum_next         = int_accum;
    ident_length_next      = ident_length;
    keyword_prefix_ok_next = keyword_prefix_ok;
    line_count_next        = line_count;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    kind_a  = K_UNKNOWN;
    kind_b  = ib.kind;
    value_a = '0;

    if (phase == PH_IDLE || phase == PH_INT || phase == PH_IDENT) begin
      if (chars.end_of_input) begin
        phase_next = PH_ENDED;
        if (phase == PH_INT) begin
          emit_a  = 1'b1;
          kind_a  = K_INTLIT;
          value_a = int_accum;
        end else if (phase == PH_IDENT) begin
          emit_a = 1'b1;
          kind_a = ident_ok ? K_CONOUT : K_UNKNOWN;
        end
      end else if (phase == PH_INT) begin
        if (is_digit(c)) begin
          int_accum_next = (int_accum << 3) + (int_accum << 1) +
                           VALUE_W'(c - 8'h30);
        end else begin
          emit_a   = 1'b1;
          kind_a   = K_INTLIT;
          value_a  = int_accum;
          run_idle = 1'b1;
        end
      end else if (phase == PH_IDENT) begin
        if (is_alpha(c) || is_digit(c) || c == 8'h5F) begin
          if (ident_length >= LEN_LIMIT) begin
            phase_next = PH_ERROR;
            emit_a     = 1'b1;
            kind_a     = K_TOOLONG;
          end else begin
            keyword_prefix_ok_next = keyword_prefix_ok &&
              (ident_length < LEN_W'(KEYWORD_LEN)) &&
              (c == KEYWORD[ident_length[2:0]]);
            ident_length_next = ident_length + 1'b1;
          end
        end else begin
          emit_a = 1'b1;
          if (ident_ok) begin
            kind_a   = K_CONOUT;
            run_idle = 1'b1;
          end else begin
            kind_a     = K_UNKNOWN;
            phase_next = PH_ERROR;
          end
        end
      end else begin
        run_idle = 1'b1;
      end
    end

    if (run_idle) begin
      phase_next = ib.phase;
      emit_b     = ib.emit;
      if (ib.newline && line_count != '1) begin
        line_count_next = line_count + 1'b1;
      end
      if (ib.start_int) begin
        int_accum_next = VALUE_W'(c - 8'h30);
      end
      if (ib.start_ident) begin
        ident_length_next      = LEN_W'(1);
        keyword_prefix_ok_next = (c == KEYWORD[0]);
      end
    end
  end

  assign n_push = accept ? (2'(emit_a) + 2'(emit_b)) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      int_accum         <= '0;
      ident_length      <= '0;
      keyword_prefix_ok <= 1'b1;
      line_count        <= LINE_W'(1);
    end else if (accept) begin
      phase             <= phase_next;
      int_accum         <= int_accum_next;
      ident_length      <= ident_length_next;
      keyword_prefix_ok <= keyword_prefix_ok_next;
      line_count        <= line_count_next;
    end
  end

  // Output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 1'b1;
      end
      tail  <= tail + QPTR_W'(n_push);
      count <= count + (QPTR_W+1)'(n_push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (emit_a) begin
        queue[tail] <= '{kind: kind_a, value: value_a, line: line_count,
                         last: !emit_b};
        if (emit_b) begin
          queue[tail + 1'b1] <= '{kind: kind_b, value: '0, line: line_count,
                                  last: 1'b1};
        end
      end else if (emit_b) begin
        queue[tail] <= '{kind: kind_b, value: '0, line: line_count, last: 1'b1};
      end
    end
  end

  assign chars.ready        = (count <= (QPTR_W+1)'(QDEPTH - 2));
  assign tokens.valid       = (count != '0);
  assign tokens.token_kind  = queue[head].kind;
  assign tokens.int_value   = queue[head].value;
  assign tokens.line_number = queue[head].line;
  assign tokens.last_of_run = queue[head].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("output queue overflow");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |=> phase == PH_ERROR)
    else $error("left error phase without reset");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (phase == PH_ENDED || phase == PH_ERROR)) |-> n_push == 2'd0)
    else $error("token produced while halted");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line counter reached zero");

  a_second_needs_first_room: assert property (@(posedge clk) disable iff (rst)
    (n_push == 2'd2) |-> (emit_a && emit_b))
    else $error("two tokens pushed without both sources");

endmodule

/* tb/char_stream_tokenizer_check.sv */
`timescale 1ns / 1ps
// Token predictor and comparator for the character stream tokenizer.
// Watches both channels; depends on cst_pkg, cst_char_if and cst_token_if.
module char_stream_tokenizer_check #(
  parameter int MAX_IDENT_LEN = cst_pkg::MAX_IDENT_LEN_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  cst_char_if   chars,
  cst_token_if  tokens,
  output int    failures,
  output int    outstanding
);
  import cst_pkg::*;

  typedef enum logic [2:0] {
    PHASE_IDLE, PHASE_INT, PHASE_IDENT, PHASE_ENDED, PHASE_ERROR
  } scan_phase_e;

  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_FF         = 8'h0C;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

  scan_phase_e       phase;
  logic [31:0]       int_accum;
  int                ident_len;
  logic              keyword_match;
  logic [LINE_W-1:0] line_cnt;

  token_t expected_tokens[$];
  token_t step_tokens[$];

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic bit is_ident(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE;
  endfunction

  function automatic void emit_token(kind_t kind, logic [31:0] value);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.line  = line_cnt;
    t.last  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void finish_ident();
    if (keyword_match && ident_len == KEYWORD_LEN) begin
      phase = PHASE_IDLE;
      emit_token(K_CONOUT, '0);
    end else begin
      phase = PHASE_ERROR;
      emit_token(K_UNKNOWN, '0);
    end
  endfunction

  function automatic void idle_byte(logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_FF: ;
      CH_LF:     if (line_cnt != '1) line_cnt++;
      CH_SEMI:   emit_token(K_SEMI, '0);
      CH_PLUS:   emit_token(K_PLUS, '0);
      CH_MINUS:  emit_token(K_MINUS, '0);
      CH_STAR:   emit_token(K_STAR, '0);
      CH_SLASH:  emit_token(K_SLASH, '0);
      CH_LPAREN: emit_token(K_LPAREN, '0);
      CH_RPAREN: emit_token(K_RPAREN, '0);
      default: begin
        if (is_digit(c)) begin
          phase     = PHASE_INT;
          int_accum = 32'(c - CH_ZERO);
        end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
          phase         = PHASE_IDENT;
          ident_len     = 1;
          keyword_match = (c == KEYWORD[0]);
        end else begin
          phase = PHASE_ERROR;
          emit_token(K_UNKNOWN, '0);
        end
      end
    endcase
  endfunction

  task automatic scan_item(input logic [7:0] c, input logic eoi);
    step_tokens.delete();
    if (phase == PHASE_ENDED || phase == PHASE_ERROR) return;
    if (eoi) begin
      if (phase == PHASE_INT) emit_token(K_INTLIT, int_accum);
      else if (phase == PHASE_IDENT) finish_ident();
      phase = PHASE_ENDED;
    end else if (phase == PHASE_INT) begin
      if (is_digit(c)) begin
        int_accum = int_accum * 32'd10 + 32'(c - CH_ZERO);
      end else begin
        emit_token(K_INTLIT, int_accum);
        phase = PHASE_IDLE;
        idle_byte(c);
      end
    end else if (phase == PHASE_IDENT) begin
      if (is_ident(c)) begin
        if (ident_len >= MAX_IDENT_LEN - 1) begin
          phase = PHASE_ERROR;
          emit_token(K_TOOLONG, '0);
        end else begin
          keyword_match = keyword_match && ident_len < KEYWORD_LEN &&
                          c == KEYWORD[ident_len < KEYWORD_LEN ? ident_len : 0];
          ident_len++;
        end
      end else begin
        // the terminating byte is only scanned when the word was accepted
        finish_ident();
        if (phase == PHASE_IDLE) idle_byte(c);
      end
    end else begin
      idle_byte(c);
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      phase         = PHASE_IDLE;
      int_accum     = '0;
      ident_len     = 0;
      keyword_match = 1'b1;
      line_cnt      = 1;
      failures      = 0;
      expected_tokens.delete();
    end else begin
      if (tokens.valid && tokens.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token transfer: token_kind %0d", tokens.token_kind);
          failures++;
        end else begin
          want = expected_tokens.pop_front();
          if (tokens.token_kind !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, tokens.token_kind);
            failures++;
          end
          if (tokens.int_value !== want.value) begin
            $error("int_value: expected %0d, got %0d", want.value, tokens.int_value);
            failures++;
          end
          if (tokens.line_number !== want.line) begin
            $error("line_number: expected %0d, got %0d", want.line, tokens.line_number);
            failures++;
          end
          if (tokens.last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, tokens.last_of_run);
            failures++;
          end
        end
      end
      if (chars.valid && chars.ready) scan_item(chars.char_byte, chars.end_of_input);
    end
    outstanding = expected_tokens.size();
  end

endmodule

/* tb/char_stream_tokenizer_tb.sv */
`timescale 1ns / 1ps
// Regression top for the character stream tokenizer: clock, reset, source text and
// token back-pressure. Depends on cst_pkg, both channel interfaces, the block and its checker.
module char_stream_tokenizer_tb;
  import cst_pkg::*;

  localparam int    MAX_IDENT_LEN = MAX_IDENT_LEN_DEFAULT;
  localparam int    DIRECTED_ITEMS = 26;
  localparam int    RANDOM_ITEMS  = 1700;
  localparam int    CYCLE_LIMIT   = 1000000;
  localparam int    DRAIN_LIMIT   = 4000;
  localparam string OPERATORS     = ";+-*/()";
  // letters and underscore first, so an index up to 52 can open a word
  localparam string IDENT_CHARS   =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum {DRAIN_FREE, DRAIN_HALF, DRAIN_SPARSE, DRAIN_BLOCKS} drain_mode_e;
  typedef enum {
    END_IDLE, END_IN_INT, END_IN_KEYWORD, END_IN_PREFIX,
    END_TOO_LONG, END_STRAY, END_BAD_WORD, END_KEYWORD_SUFFIX
  } text_end_e;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   burst_left;
  int   items_sent;
  int   failures;
  int   outstanding;

  cst_char_if  chars_if ();
  cst_token_if tokens_if ();

  char_stream_tokenizer #(.MAX_IDENT_LEN(MAX_IDENT_LEN)) dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  char_stream_tokenizer_check #(.MAX_IDENT_LEN(MAX_IDENT_LEN)) scan_check (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars_if),
    .tokens      (tokens_if),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      3:       return CH_FF;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    return OPERATORS[$urandom_range(0, OPERATORS.len() - 1)];
  endfunction

  // one byte transfer, with the sender going quiet between bursts
  task automatic send_char(input logic [7:0] c, input logic eoi);
    if (burst_left == 0) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    chars_if.valid        <= 1'b1;
    chars_if.char_byte    <= c;
    chars_if.end_of_input <= eoi;
    do @(posedge clk); while (!chars_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_int(input int digits);
    repeat (digits) send_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
  endtask

  function automatic int rand_int_len();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 4);
  endfunction

  initial begin
    drain_mode_e mode;
    int          hold;
    logic        level;
    tokens_if.ready = 1'b0;
    hold  = 0;
    level = 1'b1;
    forever begin
      mode = drain_mode_e'($urandom_range(0, 3));
      repeat ($urandom_range(20, 400)) begin
        @(negedge clk);
        case (mode)
          DRAIN_FREE:   tokens_if.ready <= 1'b1;
          DRAIN_HALF:   tokens_if.ready <= 1'($urandom_range(0, 1));
          DRAIN_SPARSE: tokens_if.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (hold == 0) begin
              level = !level;
              hold  = level ? $urandom_range(1, 6) : $urandom_range(4, 24);
            end
            hold--;
            tokens_if.ready <= level;
          end
        endcase
      end
    end
  end

  initial begin
    text_end_e ending;
    int        drain;
    rst                   = 1'b1;
    chars_if.valid        = 1'b0;
    chars_if.char_byte    = '0;
    chars_if.end_of_input = 1'b0;
    burst_left            = 0;
    items_sent            = 0;
    drain                 = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every single-byte token, keyword then newline, literal that wraps past 2^32
    send_text("(+-*/)\t;");
    send_text("conout\n");
    send_text("4294967299(");

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_char(rand_operator(), 1'b0);
        3, 4:    send_char(rand_blank(), 1'b0);
        5, 6:    send_int(rand_int_len());
        7: begin
          send_int(rand_int_len());
          send_char(rand_operator(), 1'b0);
        end
        default: begin
          send_text("conout");
          send_char($urandom_range(0, 1) ? rand_operator() : rand_blank(), 1'b0);
        end
      endcase
    end

    // the text closes one way per run; the block then ignores the rest
    ending = text_end_e'($urandom_range(0, 7));
    case (ending)
      END_IDLE: begin
        send_char(rand_blank(), 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      END_IN_INT: begin
        send_char(CH_SPACE, 1'b0);
        send_int(rand_int_len());
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      END_IN_KEYWORD: begin
        send_text(" conout");
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      END_IN_PREFIX: begin
        send_text(" cono");
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      END_TOO_LONG: begin
        send_char(CH_SPACE, 1'b0);
        send_char(IDENT_CHARS[$urandom_range(0, 52)], 1'b0);
        repeat (MAX_IDENT_LEN - 1) send_char(IDENT_CHARS[$urandom_range(0, 62)], 1'b0);
      end
      END_STRAY: begin
        send_char(CH_SPACE, 1'b0);
        case ($urandom_range(0, 2))
          0:       send_char(CH_NUL, 1'b0);
          1:       send_char(8'($urandom_range(128, 255)), 1'b0);
          default: send_char("=", 1'b0);
        endcase
      end
      END_BAD_WORD:       send_text(" Conout+");
      default:            send_text(" conout7;");
    endcase

    repeat ($urandom_range(20, 40))
      send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_char(8'hFF, 1'b0);
    send_char(CH_NUL, 1'b1);
    chars_if.valid <= 1'b0;

    while (outstanding != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (8) @(negedge clk);

    if (failures == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
